[rtl/reliable_duplicate_filter_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the duplicate filter.
// Each macro expects clk and rst_n to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef RELIABLE_DUPLICATE_FILTER_UNIT_DEFINES_SVH
`define RELIABLE_DUPLICATE_FILTER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RDF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("duplicate filter check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("duplicate filter check failed");

`endif

[rtl/rdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_pkg
// Types and constants shared by the duplicate filter modules.
// ----------------------------------------------------------------------------
package rdf_pkg;

    localparam int TIME_WIDTH   = 32;
    localparam int SEQ_IN_WIDTH = 32;

    localparam logic [TIME_WIDTH-1:0] HOLD_RESET = 32'd1000;

    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_PURGE = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic                    reliable;
        logic [SEQ_IN_WIDTH-1:0] seq_id;
        logic [TIME_WIDTH-1:0]   now;
    } in_word_t;

    typedef struct packed {
        logic is_new;
        logic table_full;
    } out_word_t;

    typedef struct packed {
        logic hit;
        logic expire;
    } cmp_res_t;

endpackage

[rtl/rdf_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_stream_if
// Valid/ready channel that carries one word per handshake.
// ----------------------------------------------------------------------------
interface rdf_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

[rtl/rdf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/rdf_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_cmp
// Shared compare unit that judges one table entry per cycle.
// ----------------------------------------------------------------------------
module rdf_cmp #(
    parameter int SEQ_WIDTH = 32
) (
    input  logic                           entry_valid,
    input  logic [SEQ_WIDTH-1:0]           entry_seq,
    input  logic [rdf_pkg::TIME_WIDTH-1:0] entry_time,
    input  logic [SEQ_WIDTH-1:0]           key,
    input  logic [rdf_pkg::TIME_WIDTH-1:0] limit,
    input  logic                           purge_en,
    output rdf_pkg::cmp_res_t              res
);

    always_comb
    begin
        res.hit    = entry_valid && (entry_seq == key);
        res.expire = entry_valid && purge_en && (entry_time < limit);
    end

endmodule

[rtl/reliable_duplicate_filter_unit.sv]
`timescale 1ns / 1ps
// An unreliable check goes from S_IDLE to S_POST; a reliable check or a purge goes through S_PRIME
// and S_SCAN, which scans one entry per cycle, to S_POST. S_POST then loads the output register.
// A new word is taken only in S_IDLE, so each scan through the one read port ends before the next word.
// A result waiting on the output does not block acceptance of the next word.
// Reset clears all valid bits at once and sets hold_reg to 1000; no clearing pass.
// ----------------------------------------------------------------------------
// reliable_duplicate_filter_unit
// Sequence id duplicate filter with aging, scanned by a small sequencer.
// ----------------------------------------------------------------------------
`include "reliable_duplicate_filter_unit_defines.svh"

module reliable_duplicate_filter_unit #(
    parameter int TABLE_ENTRIES = 64,
    parameter int SEQ_WIDTH     = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rdf_pkg::TIME_WIDTH-1:0] cfg_wdata,
    rdf_stream_if.sink                     req,
    rdf_stream_if.source                   rsp
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = SEQ_WIDTH + rdf_pkg::TIME_WIDTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRIME = 4'b0010,
        S_SCAN  = 4'b0100,
        S_POST  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [IDX_W-1:0]               cnt_reg, cnt_next;
    logic [IDX_W-1:0]               eval_reg, eval_next;
    logic [SEQ_WIDTH-1:0]           key_reg, key_next;
    logic [rdf_pkg::TIME_WIDTH-1:0] now_reg, now_next;
    logic [rdf_pkg::TIME_WIDTH-1:0] limit_reg, limit_next;
    logic [rdf_pkg::TIME_WIDTH-1:0] hold_reg, hold_next;
    logic                           purge_en_reg, purge_en_next;
    logic                           is_purge_reg, is_purge_next;
    logic                           free_found_reg, free_found_next;
    logic [IDX_W-1:0]               free_idx_reg, free_idx_next;
    logic [TABLE_ENTRIES-1:0]       valid_reg, valid_next;
    logic                           res_new_reg, res_new_next;
    logic                           res_full_reg, res_full_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_new_reg, out_new_next;
    logic                           out_full_reg, out_full_next;

    logic                           ram_we;
    logic [IDX_W-1:0]               ram_waddr;
    logic [ENTRY_W-1:0]             ram_rdata;
    logic                           free_here;
    logic                           last_entry;
    logic                           slot_avail;
    logic [IDX_W-1:0]               free_slot;
    rdf_pkg::cmp_res_t              cmp_res;

    rdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({key_reg, now_reg}),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    rdf_cmp #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_cmp (
        .entry_valid (valid_reg[eval_reg]),
        .entry_seq   (ram_rdata[ENTRY_W-1:rdf_pkg::TIME_WIDTH]),
        .entry_time  (ram_rdata[rdf_pkg::TIME_WIDTH-1:0]),
        .key         (key_reg),
        .limit       (limit_reg),
        .purge_en    (purge_en_reg),
        .res         (cmp_res)
    );

    assign free_here  = !valid_reg[eval_reg];
    assign last_entry = (eval_reg == LAST_IDX);
    assign slot_avail = free_found_reg || free_here;
    assign free_slot  = free_found_reg ? free_idx_reg : eval_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = free_slot;
        if ((state_reg == S_SCAN) && !is_purge_reg)
        begin
            if (cmp_res.hit)
            begin
                ram_we    = 1'b1;
                ram_waddr = eval_reg;
            end
            else if (last_entry && slot_avail)
            begin
                ram_we = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        eval_next       = eval_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        limit_next      = limit_reg;
        purge_en_next   = purge_en_reg;
        is_purge_next   = is_purge_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        res_new_next    = res_new_reg;
        res_full_next   = res_full_reg;
        out_valid_next  = out_valid_reg;
        out_new_next    = out_new_reg;
        out_full_next   = out_full_reg;
        hold_next       = cfg_we ? cfg_wdata : hold_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next        = SEQ_WIDTH'(req.data.seq_id);
                    now_next        = req.data.now;
                    limit_next      = req.data.now - hold_reg;
                    purge_en_next   = (req.data.now >= hold_reg);
                    is_purge_next   = (req.data.req_type == rdf_pkg::REQ_PURGE);
                    free_found_next = 1'b0;
                    cnt_next        = '0;
                    if ((req.data.req_type == rdf_pkg::REQ_CHECK) && !req.data.reliable)
                    begin
                        res_new_next  = 1'b1;
                        res_full_next = 1'b0;
                        state_next    = S_POST;
                    end
                    else
                    begin
                        state_next = S_PRIME;
                    end
                end
            end
            S_PRIME:
            begin
                cnt_next   = cnt_reg + 1'b1;
                eval_next  = cnt_reg;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cnt_next  = cnt_reg + 1'b1;
                eval_next = eval_reg + 1'b1;
                if (is_purge_reg)
                begin
                    if (cmp_res.expire)
                    begin
                        valid_next[eval_reg] = 1'b0;
                    end
                    if (last_entry)
                    begin
                        res_new_next  = 1'b0;
                        res_full_next = 1'b0;
                        state_next    = S_POST;
                    end
                end
                else if (cmp_res.hit)
                begin
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = S_POST;
                end
                else
                begin
                    if (free_here && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = eval_reg;
                    end
                    if (last_entry)
                    begin
                        res_new_next  = 1'b1;
                        res_full_next = !slot_avail;
                        if (slot_avail)
                        begin
                            valid_next[free_slot] = 1'b1;
                        end
                        state_next = S_POST;
                    end
                end
            end
            S_POST:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_new_next   = res_new_reg;
                    out_full_next  = res_full_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            is_purge_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            hold_reg       <= rdf_pkg::HOLD_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            is_purge_reg   <= is_purge_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            hold_reg       <= hold_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_reg     <= eval_next;
        key_reg      <= key_next;
        now_reg      <= now_next;
        limit_reg    <= limit_next;
        purge_en_reg <= purge_en_next;
        free_idx_reg <= free_idx_next;
        res_new_reg  <= res_new_next;
        res_full_reg <= res_full_next;
        out_new_reg  <= out_new_next;
        out_full_reg <= out_full_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.data.is_new     = out_new_reg;
    assign rsp.data.table_full = out_full_reg;

    `RDF_ASSERT_NEXT(a_hit_answers_duplicate,
        (state_reg == S_SCAN) && !is_purge_reg && cmp_res.hit,
        (state_reg == S_POST) && !res_new_reg)
    `RDF_ASSERT_NEXT(a_insert_sets_valid,
        ram_we && !cmp_res.hit,
        valid_reg[$past(ram_waddr)])
    `RDF_ASSERT_SAME(a_purge_never_writes,
        ram_we,
        (state_reg == S_SCAN) && !is_purge_reg)
    `RDF_ASSERT_SAME(a_full_only_on_new,
        rsp.valid && rsp.data.table_full,
        rsp.data.is_new)

endmodule

[test/duplicate_answer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_answer_checker
// Watches the request and answer channels of the duplicate filter. It keeps
// its own copy of the id table and the hold time, works out the answer for
// every accepted request word and compares each accepted answer word, field
// by field, with the oldest answer still owed.
// ----------------------------------------------------------------------------
module duplicate_answer_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rdf_pkg::TIME_WIDTH-1:0] cfg_wdata,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  rdf_pkg::in_word_t              req_data,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  rdf_pkg::out_word_t             rsp_data,
    output int                             mismatches,
    output int                             awaiting
);

    logic                             seen_valid [TABLE_ENTRIES];
    logic [rdf_pkg::SEQ_IN_WIDTH-1:0] seen_seq   [TABLE_ENTRIES];
    logic [rdf_pkg::TIME_WIDTH-1:0]   seen_time  [TABLE_ENTRIES];
    logic [rdf_pkg::TIME_WIDTH-1:0]   hold_ticks;
    rdf_pkg::out_word_t               owed_answers [$];
    rdf_pkg::out_word_t               want;

    function automatic rdf_pkg::out_word_t screen_header(input rdf_pkg::in_word_t w);
        rdf_pkg::out_word_t             ans;
        int                             free_slot;
        logic [rdf_pkg::TIME_WIDTH-1:0] limit;
        ans       = '0;
        free_slot = -1;
        if (w.req_type == rdf_pkg::REQ_PURGE)
        begin
            if (w.now >= hold_ticks)
            begin
                limit = w.now - hold_ticks;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (seen_valid[i] && seen_time[i] < limit)
                        seen_valid[i] = 1'b0;
                end
            end
            return ans;
        end
        if (!w.reliable)
        begin
            ans.is_new = 1'b1;
            return ans;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (seen_valid[i])
            begin
                if (seen_seq[i] == w.seq_id)
                begin
                    seen_time[i] = w.now;
                    return ans;
                end
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end
        ans.is_new = 1'b1;
        if (free_slot < 0)
        begin
            ans.table_full = 1'b1;
        end
        else
        begin
            seen_valid[free_slot] = 1'b1;
            seen_seq[free_slot]   = w.seq_id;
            seen_time[free_slot]  = w.now;
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                seen_valid[i] = 1'b0;
                seen_seq[i]   = '0;
                seen_time[i]  = '0;
            end
            hold_ticks = rdf_pkg::HOLD_RESET;
            owed_answers.delete();
            mismatches = 0;
            awaiting   = 0;
        end
        else
        begin
            if (cfg_we)
                hold_ticks = cfg_wdata;
            if (req_valid && req_ready)
                owed_answers.push_back(screen_header(req_data));
            if (rsp_valid && rsp_ready)
            begin
                if (owed_answers.size() == 0)
                begin
                    $display("%0t: answer word with none owed, actual is_new %0b table_full %0b",
                             $time, rsp_data.is_new, rsp_data.table_full);
                    mismatches++;
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (rsp_data.is_new !== want.is_new
                        || rsp_data.table_full !== want.table_full)
                    begin
                        $display("%0t: expected is_new %0b table_full %0b, %s %0b %s %0b",
                                 $time, want.is_new, want.table_full,
                                 "actual is_new", rsp_data.is_new,
                                 "table_full", rsp_data.table_full);
                        mismatches++;
                    end
                end
            end
            awaiting = owed_answers.size();
        end
    end

endmodule

[test/reliable_duplicate_filter_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reliable_duplicate_filter_unit_test
// Drives the duplicate filter with a directed opening and then bursts of
// random headers and purges over several hold times, while the answer side
// stalls on its own pattern. A checker beside the block predicts and compares
// every answer word.
// ----------------------------------------------------------------------------
module reliable_duplicate_filter_unit_test;

    localparam int TABLE_ENTRIES  = 64;
    localparam int RAND_PER_PHASE = 242;
    localparam int SETTLE_CYCLES  = TABLE_ENTRIES + 16;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [rdf_pkg::TIME_WIDTH-1:0] cfg_wdata;
    int                             long_req = 0;
    int                             burst_left;
    int                             mismatches;
    int                             awaiting;

    rdf_stream_if #(.T(rdf_pkg::in_word_t))  req_if ();
    rdf_stream_if #(.T(rdf_pkg::out_word_t)) rsp_if ();

    reliable_duplicate_filter_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .SEQ_WIDTH    (32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req_if),
        .rsp      (rsp_if)
    );

    duplicate_answer_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_if.valid),
        .req_ready (req_if.ready),
        .req_data  (req_if.data),
        .rsp_valid (rsp_if.valid),
        .rsp_ready (rsp_if.ready),
        .rsp_data  (rsp_if.data),
        .mismatches(mismatches),
        .awaiting  (awaiting)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_word(input rdf_pkg::in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            req_if.valid <= 1'b0;
            gap = $urandom_range(1, 80);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        do @(posedge clk); while (!(req_if.valid && req_if.ready));
        @(negedge clk);
        burst_left--;
    endtask

    task automatic write_hold(input logic [rdf_pkg::TIME_WIDTH-1:0] value);
        req_if.valid <= 1'b0;
        wait (awaiting == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        burst_left = 0;
    endtask

    initial
    begin
        logic [rdf_pkg::TIME_WIDTH-1:0]   tick;
        logic [rdf_pkg::TIME_WIDTH-1:0]   now_v;
        logic [rdf_pkg::SEQ_IN_WIDTH-1:0] id_base;
        logic [rdf_pkg::SEQ_IN_WIDTH-1:0] seq_v;
        logic                             rel_v;
        logic [rdf_pkg::TIME_WIDTH-1:0]   hold_plan [5];
        int                               pick;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        burst_left   = 0;
        hold_plan    = '{32'd0, 32'hFFFF_FFFF, $urandom_range(20, 400), 32'd1, 32'd1000};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word('{rdf_pkg::REQ_CHECK, 1'b0, 32'h0000_0000, 32'h0000_0000});
        send_word('{rdf_pkg::REQ_CHECK, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'h0000_0000, 32'd0});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'h0000_0000, 32'd100});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'hFFFF_FFFF, 32'd200});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'hFFFF_FFFF, 32'd300});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'h5A5A_5A5A, 32'd1100});
        send_word('{rdf_pkg::REQ_PURGE, 1'b1, 32'hFFFF_FFFF, 32'd999});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'h0000_0000, 32'd1200});
        send_word('{rdf_pkg::REQ_PURGE, 1'b0, 32'h0000_0000, 32'd1000});
        send_word('{rdf_pkg::REQ_PURGE, 1'b0, 32'h1234_5678, 32'd2250});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'hA5A5_A5A5, 32'd2300});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'hFFFF_FFFF, 32'd2301});
        send_word('{rdf_pkg::REQ_PURGE, 1'b1, 32'h0000_0000, 32'd3301});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'hFFFF_FFFF, 32'd3400});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'hA5A5_A5A5, 32'd3401});
        send_word('{rdf_pkg::REQ_PURGE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_word('{rdf_pkg::REQ_CHECK, 1'b1, 32'h5A5A_5A5A, 32'hFFFF_FFFF});

        tick    = 32'd5000;
        id_base = $urandom();
        for (int phase = 0; phase <= 5; phase++)
        begin
            if (phase > 0)
                write_hold(hold_plan[phase-1]);
            if (phase == 2)
                tick = 32'hFFFF_F800;
            long_req++;
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                tick  = tick + $urandom_range(0, 15);
                now_v = ($urandom_range(0, 49) == 0) ? $urandom() : tick;
                if ($urandom_range(0, 199) == 0)
                    id_base = $urandom();
                seq_v = ($urandom_range(0, 15) == 0) ? $urandom()
                                                     : id_base + $urandom_range(0, 79);
                rel_v = $urandom_range(0, 1);
                pick  = $urandom_range(0, 99);
                if (pick < 8)
                    send_word('{rdf_pkg::REQ_PURGE, rel_v, seq_v, now_v});
                else if (pick < 16)
                    send_word('{rdf_pkg::REQ_CHECK, 1'b0, seq_v, now_v});
                else
                    send_word('{rdf_pkg::REQ_CHECK, 1'b1, seq_v, now_v});
            end
        end

        req_if.valid <= 1'b0;
        wait (awaiting == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int mode;
        int len;
        int long_done;
        long_done    = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            if (long_req != long_done)
            begin
                long_done = long_req;
                for (int k = 0; k < 500; k++)
                begin
                    @(negedge clk);
                    rsp_if.ready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(4, 60);
            for (int i = 0; i < len; i++)
            begin
                @(negedge clk);
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= ($urandom_range(0, 2) != 0);
                    2:       rsp_if.ready <= ((i % 7) < 3);
                    default: rsp_if.ready <= (i >= len / 2);
                endcase
            end
        end
    end

    initial
    begin
        #18_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
